// ===== rtl/naca4_pkg.sv =====
// shared types, constants and coefficient tables for the naca 4-digit profile evaluator
// no dependencies; used by every module under rtl

package naca4_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int STAGES     = 12;
  localparam int DIV_SHIFT  = 28;
  localparam int X_W        = FRAC_BITS;
  localparam int HALF_LSB   = 1 << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    CFG_CAMBER    = 2'd0,
    CFG_POSITION  = 2'd1,
    CFG_THICKNESS = 2'd2
  } cfg_index_t;

  localparam logic [3:0] CAMBER_RST    = 4'd2;
  localparam logic [3:0] POSITION_RST  = 4'd4;
  localparam logic [6:0] THICKNESS_RST = 7'd12;

  // thickness polynomial coefficients, scaled by 10000
  localparam int C_SQRT = 2969;
  localparam int C_X    = 1260;
  localparam int C_X2   = 3516;
  localparam int C_X3   = 2843;
  localparam int C_X4   = 1036;

  // divide by 200000 as a shift by 6 then a divide by 3125
  localparam int YT_HALF    = 100000;
  localparam int YT_SHIFT   = 6;
  localparam int YT_DEN     = 3125;
  localparam int YT_RCP     = 85899;
  localparam int YT_MAG_MAX = 204799999;

  typedef struct packed {
    logic [31:0] op;
    logic [15:0] root;
    logic [17:0] rem;
  } sqrt_data_t;

  typedef struct packed {
    logic        neg;
    logic [27:0] mag;
    logic [11:0] den;
    logic [25:0] rcp;
  } rdiv_req_t;

  // 10 k^2
  function automatic logic [11:0] den_ten(input logic [3:0] k);
    logic [11:0] d;
    unique case (k)
      4'd1:    d = 12'd10;
      4'd2:    d = 12'd40;
      4'd3:    d = 12'd90;
      4'd4:    d = 12'd160;
      4'd5:    d = 12'd250;
      4'd6:    d = 12'd360;
      4'd7:    d = 12'd490;
      4'd8:    d = 12'd640;
      4'd9:    d = 12'd810;
      4'd10:   d = 12'd1000;
      4'd11:   d = 12'd1210;
      4'd12:   d = 12'd1440;
      4'd13:   d = 12'd1690;
      4'd14:   d = 12'd1960;
      4'd15:   d = 12'd2250;
      default: d = 12'd10;
    endcase
    return d;
  endfunction

  // floor(2^25 / (10 k^2))
  function automatic logic [22:0] rcp_ten(input logic [3:0] k);
    logic [22:0] r;
    unique case (k)
      4'd1:    r = 23'd3355443;
      4'd2:    r = 23'd838860;
      4'd3:    r = 23'd372827;
      4'd4:    r = 23'd209715;
      4'd5:    r = 23'd134217;
      4'd6:    r = 23'd93206;
      4'd7:    r = 23'd68478;
      4'd8:    r = 23'd52428;
      4'd9:    r = 23'd41425;
      4'd10:   r = 23'd33554;
      4'd11:   r = 23'd27730;
      4'd12:   r = 23'd23301;
      4'd13:   r = 23'd19854;
      4'd14:   r = 23'd17119;
      4'd15:   r = 23'd14913;
      default: r = 23'd3355443;
    endcase
    return r;
  endfunction

  // floor(2^25 / (5 k^2))
  function automatic logic [22:0] rcp_five(input logic [3:0] k);
    logic [22:0] r;
    unique case (k)
      4'd1:    r = 23'd6710886;
      4'd2:    r = 23'd1677721;
      4'd3:    r = 23'd745654;
      4'd4:    r = 23'd419430;
      4'd5:    r = 23'd268435;
      4'd6:    r = 23'd186413;
      4'd7:    r = 23'd136956;
      4'd8:    r = 23'd104857;
      4'd9:    r = 23'd82850;
      4'd10:   r = 23'd67108;
      4'd11:   r = 23'd55461;
      4'd12:   r = 23'd46603;
      4'd13:   r = 23'd39709;
      4'd14:   r = 23'd34239;
      4'd15:   r = 23'd29826;
      default: r = 23'd6710886;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/naca4_sqrt_step.sv =====
// one registered stage of the restoring square root, four result bits per stage
// depends on naca4_pkg

module naca4_sqrt_step (
  input  logic                  clk,
  input  logic                  en,
  input  naca4_pkg::sqrt_data_t d_in,
  output naca4_pkg::sqrt_data_t d_out
);

  naca4_pkg::sqrt_data_t d_nxt;
  naca4_pkg::sqrt_data_t d_r;
  logic [19:0] rem_w;
  logic [19:0] acc;
  logic [19:0] trial;

  always_comb begin
    d_nxt = d_in;
    rem_w = 20'(d_in.rem);
    acc   = '0;
    trial = '0;
    for (int i = 0; i < 4; i++) begin
      acc   = {rem_w[17:0], d_nxt.op[31:30]};
      trial = {2'b00, d_nxt.root, 2'b01};
      if (acc >= trial) begin
        rem_w      = acc - trial;
        d_nxt.root = {d_nxt.root[14:0], 1'b1};
      end else begin
        rem_w      = acc;
        d_nxt.root = {d_nxt.root[14:0], 1'b0};
      end
      d_nxt.op = {d_nxt.op[29:0], 2'b00};
    end
    d_nxt.rem = rem_w[17:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ===== rtl/naca4_rdiv.sv =====
// three-stage rounding divider: reciprocal multiply, back multiply, one correction step
// depends on naca4_pkg; the request carries the rounding half already added

module naca4_rdiv (
  input  logic                 clk,
  input  logic                 en,
  input  naca4_pkg::rdiv_req_t req,
  output logic [25:0]          quo,
  output logic                 quo_neg
);

  naca4_pkg::rdiv_req_t req1_r;
  logic [25:0] q0_nxt;
  logic [25:0] q0_r;

  logic [27:0] prod_nxt;
  logic [27:0] prod_r;
  logic [25:0] q0b_r;
  logic [27:0] mag2_r;
  logic [11:0] den2_r;
  logic        neg2_r;

  logic [27:0] rest;
  logic [25:0] quo_nxt;
  logic [25:0] quo_r;
  logic        neg3_r;

  assign q0_nxt   = 26'((54'(req.mag) * 54'(req.rcp)) >> naca4_pkg::DIV_SHIFT);
  assign prod_nxt = 28'(38'(q0_r) * 38'(req1_r.den));
  assign rest     = mag2_r - prod_r;
  assign quo_nxt  = q0b_r + 26'(rest >= 28'(den2_r));

  always_ff @(posedge clk) begin
    if (en) begin
      req1_r <= req;
      q0_r   <= q0_nxt;
      prod_r <= prod_nxt;
      q0b_r  <= q0_r;
      mag2_r <= req1_r.mag;
      den2_r <= req1_r.den;
      neg2_r <= req1_r.neg;
      quo_r  <= quo_nxt;
      neg3_r <= neg2_r;
    end
  end

  assign quo     = quo_r;
  assign quo_neg = neg3_r;

endmodule

// ===== rtl/naca4_profile_eval_top.sv =====
// naca 4-digit profile evaluator top: config registers, powers and camber datapath,
// thickness polynomial, output saturation; uses naca4_pkg, naca4_sqrt_step, naca4_rdiv
// pipeline: 12 register stages
// throughput: one request per cycle; the whole pipeline holds while a result waits
// synchronous active-low reset clears all valid bits and loads digits 2, 4 and 12

module naca4_profile_eval_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [naca4_pkg::FRAC_BITS-1:0]     in_chord_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [naca4_pkg::FRAC_BITS:0]   out_camber_height,
  output logic signed [naca4_pkg::FRAC_BITS+1:0] out_camber_gradient,
  output logic [naca4_pkg::FRAC_BITS-1:0]     out_half_thickness,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [6:0]                          cfg_wdata
);

  typedef struct packed {
    logic signed [26:0] ycn;
    logic signed [26:0] sln;
    logic [3:0]         k;
  } cam_data_t;

  logic [3:0] camber_r;
  logic [3:0] position_r;
  logic [6:0] thickness_r;

  logic                          en;
  logic [naca4_pkg::STAGES-1:0]  v_r;

  // stage 1
  logic [31:0] sq;
  logic [15:0] x2_1_nxt;
  logic [15:0] x1_r;
  logic [15:0] x2_1_r;

  // stage 2
  logic [31:0] p3;
  logic [31:0] p4;
  logic [15:0] x3_2_nxt;
  logic [15:0] x4_2_nxt;
  logic        fwd_2_nxt;
  logic [21:0] yc_fwd;
  logic [21:0] yc_in_2_nxt;
  logic [21:0] sl_in_2_nxt;
  logic [15:0] x_2_r;
  logic [15:0] x2_2_r;
  logic [15:0] x3_2_r;
  logic [15:0] x4_2_r;
  logic        fwd_2_r;
  logic signed [21:0] yc_in_2_r;
  logic signed [21:0] sl_in_2_r;

  // stage 3
  logic [29:0] pa_3_nxt;
  logic [29:0] pb_3_nxt;
  logic signed [29:0] pa_3_r;
  logic signed [29:0] pb_3_r;
  cam_data_t   cam_3_nxt;
  cam_data_t   cam_r [5];

  // stages 4 to 7
  logic signed [29:0] pc_4_r;
  logic [16:0]        s_5_nxt;
  logic [16:0]        s_5_r;
  logic signed [29:0] pc_5_r;
  logic signed [29:0] poly_6_r;
  logic [36:0]        n_7_nxt;
  logic [36:0]        n_7_r;

  // stage 8
  logic [30:0]  yt_m;
  logic [26:0]  yc_abs;
  logic [26:0]  sl_abs;
  logic [11:0]  den_yc;
  cam_data_t    cam_7;
  naca4_pkg::rdiv_req_t req_yc_nxt;
  naca4_pkg::rdiv_req_t req_sl_nxt;
  naca4_pkg::rdiv_req_t req_yt_nxt;
  naca4_pkg::rdiv_req_t req_yc_r;
  naca4_pkg::rdiv_req_t req_sl_r;
  naca4_pkg::rdiv_req_t req_yt_r;

  // stage 12
  logic [25:0] q_yc;
  logic [25:0] q_sl;
  logic [25:0] q_yt;
  logic        neg_yc;
  logic        neg_sl;
  logic        neg_yt;
  logic signed [16:0] yc_out_nxt;
  logic signed [17:0] sl_out_nxt;
  logic [15:0]        yt_out_nxt;
  logic signed [16:0] yc_out_r;
  logic signed [17:0] sl_out_r;
  logic [15:0]        yt_out_r;

  naca4_pkg::sqrt_data_t sq_in;
  naca4_pkg::sqrt_data_t sq_1;
  naca4_pkg::sqrt_data_t sq_2;
  naca4_pkg::sqrt_data_t sq_3;
  naca4_pkg::sqrt_data_t sq_4;

  assign en        = !(v_r[naca4_pkg::STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v_r[naca4_pkg::STAGES-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camber_r    <= naca4_pkg::CAMBER_RST;
      position_r  <= naca4_pkg::POSITION_RST;
      thickness_r <= naca4_pkg::THICKNESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        naca4_pkg::CFG_CAMBER:    camber_r    <= cfg_wdata[3:0];
        naca4_pkg::CFG_POSITION:  position_r  <= cfg_wdata[3:0];
        naca4_pkg::CFG_THICKNESS: thickness_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[naca4_pkg::STAGES-2:0], in_valid};
    end
  end

  // square root of x * 2^16, four bits per stage
  assign sq_in = '{op: {in_chord_position, 16'd0}, root: 16'd0, rem: 18'd0};

  naca4_sqrt_step u_sqrt_a (.clk(clk), .en(en), .d_in(sq_in), .d_out(sq_1));
  naca4_sqrt_step u_sqrt_b (.clk(clk), .en(en), .d_in(sq_1),  .d_out(sq_2));
  naca4_sqrt_step u_sqrt_c (.clk(clk), .en(en), .d_in(sq_2),  .d_out(sq_3));
  naca4_sqrt_step u_sqrt_d (.clk(clk), .en(en), .d_in(sq_3),  .d_out(sq_4));

  // powers of x, camber numerators, thickness polynomial terms and the rounded square root
  always_comb begin
    sq       = 32'(in_chord_position) * 32'(in_chord_position);
    x2_1_nxt = 16'((33'(sq) + 33'(naca4_pkg::HALF_LSB)) >> naca4_pkg::FRAC_BITS);

    p3       = 32'(x2_1_r) * 32'(x1_r);
    p4       = 32'(x2_1_r) * 32'(x2_1_r);
    x3_2_nxt = 16'((33'(p3) + 33'(naca4_pkg::HALF_LSB)) >> naca4_pkg::FRAC_BITS);
    x4_2_nxt = 16'((33'(p4) + 33'(naca4_pkg::HALF_LSB)) >> naca4_pkg::FRAC_BITS);

    fwd_2_nxt   = (20'(x1_r) * 20'(10)) < (20'(position_r) << naca4_pkg::FRAC_BITS);
    yc_fwd      = 22'(x1_r) * 22'({position_r, 1'b0}) - 22'(x2_1_r) * 22'(10);
    yc_in_2_nxt = fwd_2_nxt ? yc_fwd
                : 22'(10 << naca4_pkg::FRAC_BITS)
                  - (22'({position_r, 1'b0}) << naca4_pkg::FRAC_BITS) + yc_fwd;
    sl_in_2_nxt = (22'(position_r) << naca4_pkg::FRAC_BITS) - 22'(x1_r) * 22'(10);

    pa_3_nxt = 30'(x3_2_r) * 30'(naca4_pkg::C_X3) - 30'(x4_2_r) * 30'(naca4_pkg::C_X4);
    pb_3_nxt = 30'(0) - 30'(x2_2_r) * 30'(naca4_pkg::C_X2)
               - 30'(x_2_r) * 30'(naca4_pkg::C_X);

    cam_3_nxt.ycn = 27'(yc_in_2_r) * 27'(camber_r);
    cam_3_nxt.sln = 27'(sl_in_2_r) * 27'(camber_r);
    cam_3_nxt.k   = fwd_2_r ? position_r : 4'(4'd10 - position_r);

    s_5_nxt = 17'(sq_4.root) + 17'(sq_4.rem > 18'(sq_4.root));
    n_7_nxt = 37'(poly_6_r) * 37'(thickness_r);
  end

  // divider requests
  always_comb begin
    cam_7  = cam_r[4];
    yc_abs = cam_7.ycn[26] ? 27'(-cam_7.ycn) : 27'(cam_7.ycn);
    sl_abs = cam_7.sln[26] ? 27'(-cam_7.sln) : 27'(cam_7.sln);
    den_yc = naca4_pkg::den_ten(cam_7.k);

    req_yc_nxt.neg = cam_7.ycn[26];
    req_yc_nxt.den = den_yc;
    req_yc_nxt.mag = 28'(yc_abs) + 28'(den_yc >> 1);
    req_yc_nxt.rcp = {naca4_pkg::rcp_ten(cam_7.k), 3'b000};

    req_sl_nxt.neg = cam_7.sln[26];
    req_sl_nxt.den = den_yc >> 1;
    req_sl_nxt.mag = 28'(sl_abs) + 28'(den_yc >> 2);
    req_sl_nxt.rcp = {naca4_pkg::rcp_five(cam_7.k), 3'b000};

    yt_m           = 31'((n_7_r + 37'(naca4_pkg::YT_HALF)) >> naca4_pkg::YT_SHIFT);
    req_yt_nxt.neg = 1'b0;
    req_yt_nxt.den = 12'(naca4_pkg::YT_DEN);
    req_yt_nxt.rcp = 26'(naca4_pkg::YT_RCP);
    if (n_7_r[36]) begin
      req_yt_nxt.mag = '0;
    end else if (yt_m > 31'(naca4_pkg::YT_MAG_MAX)) begin
      req_yt_nxt.mag = 28'(naca4_pkg::YT_MAG_MAX);
    end else begin
      req_yt_nxt.mag = 28'(yt_m);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r      <= in_chord_position;
      x2_1_r    <= x2_1_nxt;
      x_2_r     <= x1_r;
      x2_2_r    <= x2_1_r;
      x3_2_r    <= x3_2_nxt;
      x4_2_r    <= x4_2_nxt;
      fwd_2_r   <= fwd_2_nxt;
      yc_in_2_r <= yc_in_2_nxt;
      sl_in_2_r <= sl_in_2_nxt;
      pa_3_r    <= pa_3_nxt;
      pb_3_r    <= pb_3_nxt;
      cam_r[0]  <= cam_3_nxt;
      for (int i = 1; i < 5; i++) begin
        cam_r[i] <= cam_r[i-1];
      end
      pc_4_r    <= pa_3_r + pb_3_r;
      s_5_r     <= s_5_nxt;
      pc_5_r    <= pc_4_r;
      poly_6_r  <= 30'(s_5_r) * 30'(naca4_pkg::C_SQRT) + pc_5_r;
      n_7_r     <= n_7_nxt;
      req_yc_r  <= req_yc_nxt;
      req_sl_r  <= req_sl_nxt;
      req_yt_r  <= req_yt_nxt;
      yc_out_r  <= yc_out_nxt;
      sl_out_r  <= sl_out_nxt;
      yt_out_r  <= yt_out_nxt;
    end
  end

  naca4_rdiv u_div_yc (.clk(clk), .en(en), .req(req_yc_r), .quo(q_yc), .quo_neg(neg_yc));
  naca4_rdiv u_div_sl (.clk(clk), .en(en), .req(req_sl_r), .quo(q_sl), .quo_neg(neg_sl));
  naca4_rdiv u_div_yt (.clk(clk), .en(en), .req(req_yt_r), .quo(q_yt), .quo_neg(neg_yt));

  // saturation to the output ranges
  always_comb begin
    if (neg_yc) begin
      yc_out_nxt = (q_yc > 26'(1 << naca4_pkg::FRAC_BITS))
                 ? 17'(-(1 << naca4_pkg::FRAC_BITS)) : 17'(26'(0) - q_yc);
    end else begin
      yc_out_nxt = (q_yc > 26'((1 << naca4_pkg::FRAC_BITS) - 1))
                 ? 17'((1 << naca4_pkg::FRAC_BITS) - 1) : 17'(q_yc);
    end
    if (neg_sl) begin
      sl_out_nxt = (q_sl > 26'(2 << naca4_pkg::FRAC_BITS))
                 ? 18'(-(2 << naca4_pkg::FRAC_BITS)) : 18'(26'(0) - q_sl);
    end else begin
      sl_out_nxt = (q_sl > 26'((2 << naca4_pkg::FRAC_BITS) - 1))
                 ? 18'((2 << naca4_pkg::FRAC_BITS) - 1) : 18'(q_sl);
    end
    if (neg_yt) begin
      yt_out_nxt = '0;
    end else begin
      yt_out_nxt = 16'(q_yt);
    end
  end

  assign out_camber_height   = yc_out_r;
  assign out_camber_gradient = sl_out_r;
  assign out_half_thickness  = yt_out_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for naca4_profile_eval_top: drives chord positions through the valid/stall
// request channel and checks camber height, slope and half-thickness against a predictor
// depends on naca4_pkg and the rtl under rtl
`timescale 1ns / 100ps

module tb_top;

  localparam longint UNIT = 64'sd1 << naca4_pkg::FRAC_BITS;
  localparam int MAX_CYCLES = 400000;

  typedef struct {
    logic signed [naca4_pkg::FRAC_BITS:0]   height;
    logic signed [naca4_pkg::FRAC_BITS+1:0] gradient;
    logic [naca4_pkg::FRAC_BITS-1:0]        thick;
  } profile_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [naca4_pkg::FRAC_BITS-1:0] in_chord_position;
  logic out_valid;
  logic out_stall;
  logic signed [naca4_pkg::FRAC_BITS:0] out_camber_height;
  logic signed [naca4_pkg::FRAC_BITS+1:0] out_camber_gradient;
  logic [naca4_pkg::FRAC_BITS-1:0] out_half_thickness;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;

  logic [naca4_pkg::FRAC_BITS-1:0] pending_pos[$];
  profile_t expected_profiles[$];
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count = 0;
  bit failed = 1'b0;

  logic [3:0] digit_c;
  logic [3:0] digit_d;
  logic [6:0] digit_tt;

  naca4_profile_eval_top dut (.*);

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint round_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
    end
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic profile_t eval_profile(logic [naca4_pkg::FRAC_BITS-1:0] pos);
    profile_t p;
    longint x, c, d, t, e, x2, x3, x4, s, yc, sl, poly, yt;
    x = longint'(pos); c = longint'(digit_c); d = longint'(digit_d);
    t = longint'(digit_tt);
    x2 = round_div(x * x, UNIT);
    x3 = round_div(x2 * x, UNIT);
    x4 = round_div(x2 * x2, UNIT);
    s = round_sqrt(x * UNIT);
    yc = 0; sl = 0;
    if (c != 0) begin
      if (10 * x < d * UNIT) begin
        yc = round_div(c * (2 * d * x - 10 * x2), 10 * d * d);
        sl = round_div(c * (d * UNIT - 10 * x), 5 * d * d);
      end else begin
        e = 10 - d;
        yc = round_div(c * (10 * UNIT - 2 * d * UNIT + 2 * d * x - 10 * x2), 10 * e * e);
        sl = round_div(c * (d * UNIT - 10 * x), 5 * e * e);
      end
    end
    poly = 2969 * s - 1260 * x - 3516 * x2 + 2843 * x3 - 1036 * x4;
    yt = round_div(t * poly, 200000);
    yc = clip(yc, -UNIT, UNIT - 1);
    sl = clip(sl, -2 * UNIT, 2 * UNIT - 1);
    yt = clip(yt, 0, UNIT - 1);
    p.height = yc[naca4_pkg::FRAC_BITS:0];
    p.gradient = sl[naca4_pkg::FRAC_BITS+1:0];
    p.thick = yt[naca4_pkg::FRAC_BITS-1:0];
    return p;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("FAIL naca4_profile_eval_top");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      expected_profiles.push_back(eval_profile(in_chord_position));
      if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_chord_position <= pending_pos.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pending_pos.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_chord_position <= pending_pos.pop_front();
    end
  end

  // monitor
  always @(posedge clk) begin
    profile_t exp_p;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_profiles.size() == 0) begin
        $display("%0t unexpected result h=%0d g=%0d t=%0d", $time, out_camber_height,
                 out_camber_gradient, out_half_thickness);
        failed = 1'b1;
      end else begin
        exp_p = expected_profiles.pop_front();
        if (out_camber_height !== exp_p.height) begin
          $display("%0t camber_height exp %0d got %0d", $time, exp_p.height, out_camber_height);
          failed = 1'b1;
        end
        if (out_camber_gradient !== exp_p.gradient) begin
          $display("%0t camber_gradient exp %0d got %0d", $time, exp_p.gradient,
                   out_camber_gradient);
          failed = 1'b1;
        end
        if (out_half_thickness !== exp_p.thick) begin
          $display("%0t half_thickness exp %0d got %0d", $time, exp_p.thick,
                   out_half_thickness);
          failed = 1'b1;
        end
      end
    end
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic wait_drained();
    while (pending_pos.size() > 0 || in_valid || expected_profiles.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(naca4_pkg::cfg_index_t idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      naca4_pkg::CFG_CAMBER:    digit_c = val[3:0];
      naca4_pkg::CFG_POSITION:  digit_d = val[3:0];
      naca4_pkg::CFG_THICKNESS: digit_tt = val;
      default: ;
    endcase
  endtask

  task automatic set_profile(logic [3:0] c, logic [3:0] d, logic [6:0] tt);
    write_reg(naca4_pkg::CFG_CAMBER, {3'd0, c});
    write_reg(naca4_pkg::CFG_POSITION, {3'd0, d});
    write_reg(naca4_pkg::CFG_THICKNESS, tt);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k == 0) pending_pos.push_back(($urandom_range(1) != 0) ? 16'hffff : 16'h0000);
      else if (k == 1) pending_pos.push_back(16'($urandom_range(255)));
      else if (k == 2)
        pending_pos.push_back(16'($urandom_range(9) * 6554 + $urandom_range(3) - 1));
      else pending_pos.push_back(16'($urandom_range(65535)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = naca4_pkg::CFG_CAMBER;
    cfg_wdata = '0;
    digit_c = naca4_pkg::CAMBER_RST;
    digit_d = naca4_pkg::POSITION_RST;
    digit_tt = naca4_pkg::THICKNESS_RST;
    send_idle_pct = 37;
    recv_idle_pct = 78;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset profile, edges, branch boundary, odd digits
    pending_pos.push_back(16'h0000); pending_pos.push_back(16'h0001);
    pending_pos.push_back(16'h8000); pending_pos.push_back(16'hffff);
    pending_pos.push_back(16'd26214); pending_pos.push_back(16'd26215);
    pending_pos.push_back(16'h5555); pending_pos.push_back(16'haaaa);
    wait_drained();
    set_profile(4'd0, 4'd0, 7'd0);
    pending_pos.push_back(16'h0000); pending_pos.push_back(16'hffff);
    pending_pos.push_back(16'h4000);
    wait_drained();
    set_profile(4'd15, 4'd1, 7'd127);
    pending_pos.push_back(16'h0000); pending_pos.push_back(16'd6553);
    pending_pos.push_back(16'd6554); pending_pos.push_back(16'hffff);
    wait_drained();
    set_profile(4'd9, 4'd15, 7'd99);
    pending_pos.push_back(16'h0000); pending_pos.push_back(16'hffff);
    pending_pos.push_back(16'h7fff);
    wait_drained();
    set_profile(4'd9, 4'd0, 7'd1);
    pending_pos.push_back(16'h0000); pending_pos.push_back(16'hffff);
    pending_pos.push_back(16'h0003);
    wait_drained();

    // random phases over several profiles and idling modes
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 78; recv_idle_pct = 37; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph % 3 == 0) set_profile(4'd9, 4'd9, 7'd99);
      else set_profile(4'($urandom_range(15)), 4'($urandom_range(15)),
                       7'($urandom_range(127)));
      queue_random(160);
      wait_drained();
    end

    if (!failed) begin
      $display("PASS naca4_profile_eval_top");
    end else begin
      $display("FAIL naca4_profile_eval_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/naca4_pkg.sv
rtl/naca4_sqrt_step.sv
rtl/naca4_rdiv.sv
rtl/naca4_profile_eval_top.sv
tb/sv/tb_top.sv
